>>> rtl/brlam_pkg.sv
// Shared types, constants and helpers for the block ring log address manager.
package brlam_pkg;

  localparam int NUM_BLOCKS        = 48;
  localparam int ENTRIES_PER_BLOCK = 128;
  localparam int RESERVED_SLOTS    = 8;
  localparam int BLK_W             = $clog2(NUM_BLOCKS);
  localparam int CNT_W             = 8;
  localparam int SLOT_W            = 13;
  localparam int ADDR_W            = 16;
  localparam int REQ_W             = 2;
  localparam int BLOCK_SHIFT       = 10;
  localparam int ENTRY_SHIFT       = 3;
  localparam logic [ADDR_W-1:0] LOG_BASE = 16'h4000;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_READ   = 2'd1,
    REQ_WIPE   = 2'd2
  } req_code_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SLOT_W-1:0] read_slot;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] entry_address;
    logic              found;
  } res_t;

  typedef struct packed {
    logic capture;
    logic append;
    logic walk_step;
    logic wipe;
    logic load_zero;
  } cmd_t;

  typedef struct packed {
    logic walk_hit;
    logic walk_end;
  } status_t;

  function automatic logic [BLK_W-1:0] next_block(input logic [BLK_W-1:0] b);
    next_block = (b == BLK_W'(NUM_BLOCKS - 1)) ? '0 : b + 1'b1;
  endfunction

  function automatic logic [BLK_W-1:0] prev_block(input logic [BLK_W-1:0] b);
    prev_block = (b == '0) ? BLK_W'(NUM_BLOCKS - 1) : b - 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] reset_count(input logic [BLK_W-1:0] b);
    reset_count = (b == '0) ? CNT_W'(RESERVED_SLOTS) : '0;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [BLK_W-1:0] b,
                                               input logic [CNT_W-1:0] slot);
    addr_of = LOG_BASE + (ADDR_W'(b) << BLOCK_SHIFT) + (ADDR_W'(slot) << ENTRY_SHIFT);
  endfunction

endpackage

>>> rtl/brlam_ctrl.sv
// Controller state machine sequencing append, read walk and wipe requests.
module brlam_ctrl
  import brlam_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  status_t          status,
  output cmd_t             cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_WALK
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    done_next  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_APPEND: begin
              state_next = ST_APPEND;
            end
            REQ_READ: begin
              cmd.capture = 1'b1;
              state_next  = ST_WALK;
            end
            REQ_WIPE: begin
              cmd.wipe      = 1'b1;
              cmd.load_zero = 1'b1;
              done_next     = 1'b1;
            end
            default: begin
              cmd.load_zero = 1'b1;
              done_next     = 1'b1;
            end
          endcase
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_hit || status.walk_end) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

>>> rtl/brlam_dp.sv
// Datapath: fill-count memory, head and tail pointers, walk counter and result word.
module brlam_dp
  import brlam_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [SLOT_W-1:0] read_slot,
  output status_t           status,
  output res_t              result
);

  logic [CNT_W-1:0]      mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid;
  logic [BLK_W-1:0]      head;
  logic [BLK_W-1:0]      tail;
  logic [BLK_W-1:0]      walk_b;
  logic [BLK_W-1:0]      blk_q;
  logic [CNT_W-1:0]      rdata;
  logic                  vbit_q;
  logic [SLOT_W-1:0]     remain;

  logic [BLK_W-1:0]      raddr;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      lo;
  logic [CNT_W-1:0]      valid_n;
  logic [CNT_W:0]        cnt_inc;
  logic                  full;
  logic [BLK_W-1:0]      head_adv;
  logic                  mem_we;
  logic [CNT_W-1:0]      mem_wdata;

  assign raddr    = cmd.walk_step ? walk_b : head;
  assign cnt      = vbit_q ? rdata : reset_count(blk_q);
  assign lo       = reset_count(blk_q);
  assign valid_n  = (cnt > lo) ? cnt - lo : '0;
  assign cnt_inc  = {1'b0, cnt} + 1'b1;
  assign full     = (cnt_inc >= (CNT_W + 1)'(ENTRIES_PER_BLOCK));
  assign head_adv = next_block(head);
  assign mem_we   = cmd.append;
  assign mem_wdata = full ? CNT_W'(ENTRIES_PER_BLOCK) : cnt_inc[CNT_W-1:0];

  assign status.walk_hit = ({{(SLOT_W - CNT_W){1'b0}}, valid_n} > remain);
  assign status.walk_end = (blk_q == tail);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head] <= mem_wdata;
    end
    rdata  <= mem[raddr];
    vbit_q <= valid[raddr];
    blk_q  <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.wipe) begin
      valid <= '0;
      head  <= '0;
      tail  <= '0;
    end else if (cmd.append) begin
      valid[head] <= 1'b1;
      if (full) begin
        valid[head_adv] <= 1'b0;
        head            <= head_adv;
        if (head_adv == tail) begin
          tail <= next_block(tail);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      remain <= read_slot;
      walk_b <= prev_block(head);
    end else if (cmd.walk_step) begin
      walk_b <= prev_block(walk_b);
      remain <= remain - {{(SLOT_W - CNT_W){1'b0}}, valid_n};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_zero) begin
      result <= '0;
    end else if (cmd.append) begin
      result.entry_address <= addr_of(head, cnt);
      result.found         <= 1'b1;
    end else if (cmd.walk_step) begin
      if (status.walk_hit) begin
        result.entry_address <= addr_of(blk_q, CNT_W'(cnt - 1'b1 - remain[CNT_W-1:0]));
        result.found         <= 1'b1;
      end else if (status.walk_end) begin
        result <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head < BLK_W'(NUM_BLOCKS)) else $error("head out of range");

  a_tail_range: assert property (@(posedge clk) disable iff (rst)
    tail < BLK_W'(NUM_BLOCKS)) else $error("tail out of range");

  a_tail_moves: assert property (@(posedge clk) disable iff (rst)
    cmd.append && full && (head_adv == tail) |=> head != tail)
    else $error("head landed on tail");
`endif

endmodule

>>> rtl/block_ring_log_address_manager_unit.sv
// Top level of the block ring log address manager: controller plus datapath.
// Append: result word strobes after the append state; wipe: in the cycle after the start cycle.
// Read: walks 1 to NUM_BLOCKS blocks back from head; walk checks one block count per cycle.
// A new request may start in the cycle its predecessor's result is strobed.
// Synchronous reset clears head, tail and the per-block valid flags at once; no clearing pass.
// The receiver cannot stall: each result word is shown for one cycle with done.
module block_ring_log_address_manager_unit
  import brlam_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output res_t result
);

  cmd_t    cmd;
  status_t status;

  brlam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (request.req_type),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  brlam_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .read_slot (request.read_slot),
    .status    (status),
    .result    (result)
  );

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("accepted request dropped");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.entry_address == '0)
    else $error("miss with nonzero address");
`endif

endmodule

>>> tb/sv/brlam_checker.sv
// Checker for the ring log address manager: tracks the fill table and compares each result word.
module brlam_checker
  import brlam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        request,
  input  logic        done,
  input  res_t        result,
  output int unsigned errors,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CNT_W-1:0] fill_cnt [NUM_BLOCKS];
  logic [BLK_W-1:0] head_blk;
  logic [BLK_W-1:0] tail_blk;
  res_t             expected_q [$];
  res_t             want_word;

  function automatic logic [ADDR_W-1:0] slot_address(input int blk, input int slot);
    return ADDR_W'(32'h4000 + blk * 1024 + slot * 8);
  endfunction

  function automatic int wrap_fwd(input int blk);
    return (blk + 1 >= NUM_BLOCKS) ? 0 : blk + 1;
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < NUM_BLOCKS; i++) fill_cnt[i] = '0;
    fill_cnt[0] = CNT_W'(RESERVED_SLOTS);
    head_blk    = '0;
    tail_blk    = '0;
  endfunction

  function automatic res_t predict_word(input req_t w);
    res_t o;
    int   cnt;
    int   blk;
    int   age;
    int   floor_cnt;
    int   live;
    bit   stop;
    o = '0;
    case (w.req_type)
      REQ_APPEND: begin
        cnt             = int'(fill_cnt[head_blk]);
        o.entry_address = slot_address(int'(head_blk), cnt);
        o.found         = 1'b1;
        cnt++;
        if (cnt >= ENTRIES_PER_BLOCK) begin
          fill_cnt[head_blk] = CNT_W'(ENTRIES_PER_BLOCK);
          head_blk           = BLK_W'(wrap_fwd(int'(head_blk)));
          fill_cnt[head_blk] = (head_blk == '0) ? CNT_W'(RESERVED_SLOTS) : '0;
          if (head_blk == tail_blk) tail_blk = BLK_W'(wrap_fwd(int'(tail_blk)));
        end else begin
          fill_cnt[head_blk] = CNT_W'(cnt);
        end
      end
      REQ_READ: begin
        blk  = int'(head_blk);
        age  = int'(w.read_slot);
        stop = 1'b0;
        for (int n = 0; n < NUM_BLOCKS && !stop; n++) begin
          cnt       = int'(fill_cnt[blk]);
          floor_cnt = (blk == 0) ? RESERVED_SLOTS : 0;
          live      = (cnt > floor_cnt) ? cnt - floor_cnt : 0;
          if (live > age) begin
            o.entry_address = slot_address(blk, cnt - 1 - age);
            o.found         = 1'b1;
            stop            = 1'b1;
          end else if (blk == int'(tail_blk)) begin
            stop = 1'b1;
          end else begin
            age -= live;
            blk  = (blk == 0) ? NUM_BLOCKS - 1 : blk - 1;
          end
        end
      end
      REQ_WIPE: clear_ring();
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_ring();
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word: address %h found %b", $time,
                   result.entry_address, result.found);
          errors++;
        end else begin
          want_word = expected_q.pop_front();
          if (result.entry_address !== want_word.entry_address) begin
            $display("%0t: entry_address mismatch: expected %h, actual %h", $time,
                     want_word.entry_address, result.entry_address);
            errors++;
          end
          if (result.found !== want_word.found) begin
            $display("%0t: found mismatch: expected %b, actual %b", $time,
                     want_word.found, result.found);
            errors++;
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_word(request));
    end
    pending = expected_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the ring log address manager: clock, reset, request words and verdict.
module tb_top;
  import brlam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               CYCLE_LIMIT = 2_000_000;
  localparam logic [REQ_W-1:0] REQ_SPARE   = 2'd3;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        done;
  req_t        request;
  res_t        result;
  int unsigned errors;
  int unsigned pending;

  block_ring_log_address_manager_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  brlam_checker chk (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int rand_slot();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 15);
      1:       return $urandom_range(0, 400);
      2:       return $urandom_range(0, 8191);
      default: return $urandom_range(5900, 6300);
    endcase
  endfunction

  function automatic req_t make_word(input logic [REQ_W-1:0] code, input int slot);
    req_t w;
    w.req_type  = code;
    w.read_slot = SLOT_W'(slot);
    return w;
  endfunction

  function automatic req_t rand_word(input int append_pct, input int read_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < append_pct) return make_word(REQ_APPEND, rand_slot());
    if (pick < append_pct + read_pct) return make_word(REQ_READ, rand_slot());
    return make_word(pick[0] ? REQ_WIPE : REQ_SPARE, rand_slot());
  endfunction

  // hold start until the word is taken
  task automatic send_word(input req_t w);
    @(negedge clk);
    start   = 1'b1;
    request = w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start              = 1'b0;
      request.req_type   = REQ_W'($urandom_range(0, 3));
      request.read_slot  = SLOT_W'($urandom_range(0, 8191));
    end
  endtask

  task automatic pause_maybe(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 8));
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    bit quiet;
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    quiet   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(make_word(REQ_READ, 0));
    send_word(make_word(REQ_APPEND, 8191));
    send_word(make_word(REQ_READ, 0));
    send_word(make_word(REQ_READ, 1));
    send_word(make_word(REQ_READ, 8191));
    send_word(make_word(REQ_SPARE, 8191));
    send_word(make_word(REQ_SPARE, 0));
    send_word(make_word(REQ_APPEND, 0));
    hold_off(3);
    send_word(make_word(REQ_APPEND, 0));
    send_word(make_word(REQ_APPEND, 0));
    send_word(make_word(REQ_READ, 3));
    send_word(make_word(REQ_READ, 4));
    send_word(make_word(REQ_READ, 6143));
    send_word(make_word(REQ_WIPE, 8191));
    send_word(make_word(REQ_READ, 0));
    send_word(make_word(REQ_APPEND, 0));
    send_word(make_word(REQ_WIPE, 0));
    send_word(make_word(REQ_APPEND, 0));

    for (int i = 0; i < 500; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
      send_word(rand_word(55, 38));
      pause_maybe(!quiet);
    end

    // run mostly appends so head crosses several blocks
    for (int i = 0; i < 330; i++) begin
      send_word(($urandom_range(0, 15) == 0) ? make_word(REQ_READ, rand_slot())
                                             : make_word(REQ_APPEND, $urandom_range(0, 8191)));
      pause_maybe($urandom_range(0, 7) == 0);
    end

    for (int i = 0; i < 100; i++) send_word(rand_word(28, 68));

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (NUM_BLOCKS + 8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/brlam_pkg.sv
rtl/brlam_ctrl.sv
rtl/brlam_dp.sv
rtl/block_ring_log_address_manager_unit.sv
tb/sv/brlam_checker.sv
tb/sv/tb_top.sv
